// ===== rtl/b2y_pkg.sv =====
// ----------------------------------------------------------------------------
// b2y_pkg
// Shared types, chroma coefficient sets and the chroma finishing function
// for the BGR pair to packed 4:2:2 converter.
// ----------------------------------------------------------------------------
package b2y_pkg;

    localparam int CHAN_W   = 8;
    localparam int PSUM_W   = CHAN_W + 1;
    localparam int COEF_W   = 8;
    localparam int CSUM_W   = 19;
    localparam int CSHIFT   = 9;
    localparam int COFFSET  = 128;

    typedef enum logic {
        PACK_UYVY = 1'b0,
        PACK_YUY2 = 1'b1
    } t_pack_mode;

    typedef struct packed {
        logic signed [COEF_W-1:0] kr;
        logic signed [COEF_W-1:0] kg;
        logic signed [COEF_W-1:0] kb;
    } t_chroma_coef;

    localparam t_chroma_coef C_U_UYVY = '{kr: -8'sd38, kg: -8'sd74,  kb: 8'sd112};
    localparam t_chroma_coef C_V_UYVY = '{kr: 8'sd112, kg: -8'sd94,  kb: -8'sd18};
    localparam t_chroma_coef C_U_YUY2 = '{kr: -8'sd43, kg: -8'sd84,  kb: 8'sd127};
    localparam t_chroma_coef C_V_YUY2 = '{kr: 8'sd127, kg: -8'sd106, kb: -8'sd21};

    // floor(sum / 512) + 128, saturated to a byte
    function automatic logic [CHAN_W-1:0] chroma_finish(
        input logic signed [CSUM_W-1:0] sum
    );
        logic signed [CSUM_W-CSHIFT-1:0] shifted;
        logic signed [CSUM_W-CSHIFT:0]   biased;
        logic [CHAN_W-1:0]               res;
        shifted = (CSUM_W-CSHIFT)'(sum >>> CSHIFT);
        biased  = (CSUM_W-CSHIFT+1)'(shifted) + (CSUM_W-CSHIFT+1)'(COFFSET);
        if (biased < 0) begin
            res = '0;
        end else if (biased > (CSUM_W-CSHIFT+1)'(255)) begin
            res = '1;
        end else begin
            res = biased[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/b2y_luma_lane.sv =====
// ----------------------------------------------------------------------------
// b2y_luma_lane
// One luma lane: (77R + 150G + 29B) >> 8 of one pixel, registered.
// ----------------------------------------------------------------------------
module b2y_luma_lane
    import b2y_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [CHAN_W-1:0] i_r,
    input  logic [CHAN_W-1:0] i_g,
    input  logic [CHAN_W-1:0] i_b,
    output logic [CHAN_W-1:0] o_y
);

    logic [2*CHAN_W-1:0] w_sum;
    logic [CHAN_W-1:0]   r_y;

    // weights add up to 256, so the sum never exceeds 16 bits
    assign w_sum = (2*CHAN_W)'(i_r) * (2*CHAN_W)'(77)
                 + (2*CHAN_W)'(i_g) * (2*CHAN_W)'(150)
                 + (2*CHAN_W)'(i_b) * (2*CHAN_W)'(29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= w_sum[2*CHAN_W-1:CHAN_W];
        end
    end

    assign o_y = r_y;

endmodule

// ===== rtl/b2y_chroma_lane.sv =====
// ----------------------------------------------------------------------------
// b2y_chroma_lane
// One chroma lane: weighted sum of the pair sums, registered before finishing.
// ----------------------------------------------------------------------------
module b2y_chroma_lane
    import b2y_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [PSUM_W-1:0]        i_rs,
    input  logic [PSUM_W-1:0]        i_gs,
    input  logic [PSUM_W-1:0]        i_bs,
    input  t_chroma_coef             i_coef,
    output logic signed [CSUM_W-1:0] o_sum
);

    logic signed [PSUM_W+COEF_W:0] w_pr;
    logic signed [PSUM_W+COEF_W:0] w_pg;
    logic signed [PSUM_W+COEF_W:0] w_pb;
    logic signed [CSUM_W-1:0]      n_sum;
    logic signed [CSUM_W-1:0]      r_sum;

    assign w_pr  = $signed({1'b0, i_rs}) * i_coef.kr;
    assign w_pg  = $signed({1'b0, i_gs}) * i_coef.kg;
    assign w_pb  = $signed({1'b0, i_bs}) * i_coef.kb;
    assign n_sum = CSUM_W'(w_pr) + CSUM_W'(w_pg) + CSUM_W'(w_pb);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/b2y_pack.sv =====
// ----------------------------------------------------------------------------
// b2y_pack
// Merge stage: finish both chroma lanes, order the four bytes by mode and
// hold the word in the output register.
// ----------------------------------------------------------------------------
module b2y_pack
    import b2y_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pack_mode               i_mode,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CHAN_W-1:0]        i_y0,
    input  logic [CHAN_W-1:0]        i_y1,
    input  logic signed [CSUM_W-1:0] i_usum,
    input  logic signed [CSUM_W-1:0] i_vsum,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [4*CHAN_W-1:0]      o_data
);

    logic [CHAN_W-1:0]   w_u;
    logic [CHAN_W-1:0]   w_v;
    logic [4*CHAN_W-1:0] n_data;
    logic [4*CHAN_W-1:0] r_data;
    logic                r_valid;
    logic                w_load;

    assign w_u     = chroma_finish(i_usum);
    assign w_v     = chroma_finish(i_vsum);
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        unique case (i_mode)
            PACK_UYVY: n_data = {i_y1, w_v, i_y0, w_u};
            PACK_YUY2: n_data = {w_v, i_y1, w_u, i_y0};
            default:   n_data = {i_y1, w_v, i_y0, w_u};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/bgr_to_packed_yuv422_top.sv =====
// ----------------------------------------------------------------------------
// bgr_to_packed_yuv422_top
// BGR pixel pair to packed 4:2:2 word (UYVY or YUY2 order).
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one word per horizontal pixel pair, six 8-bit channels.
//   Master stream m_*: one packed 4:2:2 word of four bytes per input word.
//   i_cfg_we / i_cfg_wdata write the packing mode (0 UYVY, 1 YUY2); write
//   it only while no word is in flight.
//   Two luma lanes and two chroma lanes run side by side in the first stage;
//   the merge stage finishes chroma, orders the bytes and holds the word in
//   the output register.
//   An accepted s_ word passes the lane registers, then the output register.
//   Throughput: one word per cycle while m_tready stays high.
//   Reset empties both stages and sets UYVY mode.
//   When m_tready is low the output word holds; the lane stage still takes
//   one more word, then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module bgr_to_packed_yuv422_top
    import b2y_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // blue_first, green_first, red_first, blue_second, green_second, red_second
    input  logic [6*CHAN_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_byte0, out_byte1, out_byte2, out_byte3
    output logic [4*CHAN_W-1:0] m_tdata
);

    t_pack_mode               r_mode;
    logic                     r_v1;
    logic                     w_en1;
    logic                     w_pack_ready;
    logic [CHAN_W-1:0]        w_b1, w_g1, w_r1, w_b2, w_g2, w_r2;
    logic [PSUM_W-1:0]        w_rs, w_gs, w_bs;
    t_chroma_coef             w_ucoef, w_vcoef;
    logic [CHAN_W-1:0]        w_y0, w_y1;
    logic signed [CSUM_W-1:0] w_usum, w_vsum;

    assign w_b1 = s_tdata[0*CHAN_W +: CHAN_W];
    assign w_g1 = s_tdata[1*CHAN_W +: CHAN_W];
    assign w_r1 = s_tdata[2*CHAN_W +: CHAN_W];
    assign w_b2 = s_tdata[3*CHAN_W +: CHAN_W];
    assign w_g2 = s_tdata[4*CHAN_W +: CHAN_W];
    assign w_r2 = s_tdata[5*CHAN_W +: CHAN_W];

    assign w_rs = PSUM_W'(w_r1) + PSUM_W'(w_r2);
    assign w_gs = PSUM_W'(w_g1) + PSUM_W'(w_g2);
    assign w_bs = PSUM_W'(w_b1) + PSUM_W'(w_b2);

    always_comb begin
        unique case (r_mode)
            PACK_UYVY: begin
                w_ucoef = C_U_UYVY;
                w_vcoef = C_V_UYVY;
            end
            PACK_YUY2: begin
                w_ucoef = C_U_YUY2;
                w_vcoef = C_V_YUY2;
            end
            default: begin
                w_ucoef = C_U_UYVY;
                w_vcoef = C_V_UYVY;
            end
        endcase
    end

    assign w_en1    = !r_v1 || w_pack_ready;
    assign s_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PACK_UYVY;
        end else if (i_cfg_we) begin
            r_mode <= t_pack_mode'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= s_tvalid;
        end
    end

    b2y_luma_lane u_luma0 (
        .i_clk (i_clk),
        .i_en  (w_en1),
        .i_r   (w_r1),
        .i_g   (w_g1),
        .i_b   (w_b1),
        .o_y   (w_y0)
    );

    b2y_luma_lane u_luma1 (
        .i_clk (i_clk),
        .i_en  (w_en1),
        .i_r   (w_r2),
        .i_g   (w_g2),
        .i_b   (w_b2),
        .o_y   (w_y1)
    );

    b2y_chroma_lane u_chroma_u (
        .i_clk  (i_clk),
        .i_en   (w_en1),
        .i_rs   (w_rs),
        .i_gs   (w_gs),
        .i_bs   (w_bs),
        .i_coef (w_ucoef),
        .o_sum  (w_usum)
    );

    b2y_chroma_lane u_chroma_v (
        .i_clk  (i_clk),
        .i_en   (w_en1),
        .i_rs   (w_rs),
        .i_gs   (w_gs),
        .i_bs   (w_bs),
        .i_coef (w_vcoef),
        .o_sum  (w_vsum)
    );

    b2y_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (r_v1),
        .o_ready (w_pack_ready),
        .i_y0    (w_y0),
        .i_y1    (w_y1),
        .i_usum  (w_usum),
        .i_vsum  (w_vsum),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !m_tvalid)
        else $error("pipeline not empty after reset");

    a_accept_fills_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> r_v1)
        else $error("accepted word lost in lane stage");

    a_lanes_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_pack_ready |=> r_v1 && $stable(w_y0) && $stable(w_y1)
            && $stable(w_usum) && $stable(w_vsum))
        else $error("lane stage changed while stalled");

    a_lanes_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_pack_ready |=> m_tvalid)
        else $error("lane result not moved to output");

endmodule
